[rtl/core/batch_perceptron_trainer_assert.svh]
// Assertion macros shared by the batch perceptron trainer RTL.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef BATCH_PERCEPTRON_TRAINER_ASSERT_SVH
`define BATCH_PERCEPTRON_TRAINER_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPT_ASSERT(lbl, prop, msg)
`define BPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/bpt_pkg.sv]
// Shared types, constants and the saturation helper of the batch perceptron trainer.
// Depends on nothing.
package bpt_pkg;

  localparam int NUM_WEIGHTS_DEF = 1024;

  localparam logic [1:0] OP_FEATURE = 2'd0;
  localparam logic [1:0] OP_EPOCH   = 2'd1;
  localparam logic [1:0] OP_RESET_W = 2'd2;

  localparam logic KIND_SCORE = 1'b0;
  localparam logic KIND_EPOCH = 1'b1;

  localparam logic signed [31:0] RESET_WEIGHT = 32'sd4096;
  localparam logic [10:0] MAX_LEN = 11'd2047;
  localparam logic [23:0] MAX_ERR = 24'hFFFFFF;

  typedef struct packed {
    logic mul_en;
    logic clr;
  } mac_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat32 = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

[rtl/core/bpt_in_if.sv]
// Input channel interface of the batch perceptron trainer.
// Depends on nothing; payload widths are fixed.
interface bpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [9:0]  feature_index;
  logic signed [15:0] feature_value;
  logic        label_positive;
  logic        train;
  logic        last;

  modport source(output valid, opcode, feature_index, feature_value, label_positive,
                 train, last, input ready);
  modport sink(input valid, opcode, feature_index, feature_value, label_positive,
               train, last, output ready);
endinterface

[rtl/core/bpt_out_if.sv]
// Result channel interface of the batch perceptron trainer.
// Depends on nothing; payload widths are fixed.
interface bpt_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [47:0] score;
  logic        misclassified;
  logic [23:0] epoch_errors;
  logic        converged;

  modport source(output valid, kind, score, misclassified, epoch_errors, converged,
                 input ready);
  modport sink(input valid, kind, score, misclassified, epoch_errors, converged,
               output ready);
endinterface

[rtl/core/batch_perceptron_trainer.sv]
// Top level of the batch perceptron trainer: sequencer, weight, delta and sample memories.
// Depends on bpt_pkg, bpt_in_if, bpt_out_if, bpt_mac and the assertion header.
//
// Usage. Items arrive on in_ch (valid/ready); a transaction is accepted when both are high.
// A feature item (opcode 0) first reads its weight from the weight memory, then multiplies;
// the product is folded into the score after it is registered, and the block takes no new
// item while it multiplies. The item marked last then forms the saturated score and loads
// it into the output register once that register is free. On a misclassified training
// sample the block then walks the sample buffer and delta memory, one entry per cycle,
// over min(sample length, NUM_WEIGHTS) entries, through their single read ports.
// An end-of-epoch item emits its report and then walks all NUM_WEIGHTS weight and delta
// entries. A reset-weights item writes the configured initial weight to every weight entry.
// After reset a clearing pass writes every weight and delta entry, during which
// in_ch.ready stays low; cfg writes are taken whenever reset is not asserted.
// Results leave on out_ch from a single output register. A stalled receiver only holds
// the block when a new result must be loaded while the previous one is still waiting.
`include "batch_perceptron_trainer_assert.svh"
module batch_perceptron_trainer #(
  parameter int NUM_WEIGHTS = bpt_pkg::NUM_WEIGHTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_wdata,
  bpt_in_if.sink             in_ch,
  bpt_out_if.source          out_ch
);

  localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
  localparam int PW = AW + 1;
  localparam logic [16:0] NW17 = 17'(NUM_WEIGHTS);
  localparam logic [PW-1:0] NWP = PW'(NUM_WEIGHTS);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_DWALK = 3'd4;
  localparam logic [2:0] S_EREP  = 3'd5;
  localparam logic [2:0] S_EWALK = 3'd6;
  localparam logic [2:0] S_RWALK = 3'd7;

  // The three memories; each has one write and one registered read port.
  logic signed [31:0] weight_mem [NUM_WEIGHTS];
  logic signed [31:0] delta_mem  [NUM_WEIGHTS];
  logic signed [15:0] sample_mem [NUM_WEIGHTS];

  logic signed [31:0] w_rd_r, d_rd_r;
  logic signed [15:0] b_rd_r;
  logic               w_we, d_we, b_we;
  logic [AW-1:0]      w_wa, d_wa, b_wa, w_ra, d_ra, b_ra;
  logic signed [31:0] w_wd, d_wd;

  logic [2:0]  state_r, state_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt, wlen_r, wlen_nxt;
  logic        wv_r, wv_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic [10:0] len_r, len_nxt;
  logic [23:0] err_r, err_nxt;
  logic signed [31:0] init_w_r;

  logic signed [15:0] val_r;
  logic        inr_r, last_r, pos_r, train_r;

  logic        out_vld_r, out_vld_nxt, out_load;
  logic        out_kind_nxt, out_miss_nxt, out_conv_nxt;
  logic signed [47:0] out_score_nxt;
  logic [23:0] out_err_nxt;
  logic        out_kind_r, out_miss_r, out_conv_r;
  logic signed [47:0] out_score_r;
  logic [23:0] out_err_r;

  bpt_pkg::mac_ctrl_t mac_ctrl;
  logic signed [63:0] acc_eff;
  logic signed [47:0] score_sat;
  logic        miss;
  logic        accept, slot_free, in_range, rd_issue;
  logic [16:0] idx17, len17, n17;
  logic signed [16:0] step;

  bpt_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mac_ctrl),
    .weight  (w_rd_r),
    .value   (val_r),
    .acc_eff (acc_eff)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_vld_r || out_ch.ready;
  assign idx17       = {7'd0, in_ch.feature_index};
  assign in_range    = idx17 < NW17;
  assign len17       = {6'd0, len_r};
  assign n17         = (len17 < NW17) ? len17 : NW17;
  assign rd_issue    = ptr_r < wlen_r;

  // Score saturates to 48 bits when the upper 17 bits disagree with the sign.
  always_comb begin
    if (acc_eff[63:47] != {17{acc_eff[63]}}) begin
      score_sat = acc_eff[63] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      score_sat = acc_eff[47:0];
    end
  end

  assign miss = train_r && (pos_r ? score_sat[47] : (!score_sat[47] && score_sat != '0));
  assign step = pos_r ? 17'(b_rd_r) : -17'(b_rd_r);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    wlen_nxt      = wlen_r;
    wv_nxt        = 1'b0;
    wa_nxt        = wa_r;
    len_nxt       = len_r;
    err_nxt       = err_r;
    mac_ctrl      = '0;
    out_load      = 1'b0;
    out_kind_nxt  = bpt_pkg::KIND_SCORE;
    out_score_nxt = '0;
    out_miss_nxt  = 1'b0;
    out_err_nxt   = '0;
    out_conv_nxt  = 1'b0;
    w_we = 1'b0; w_wa = wa_r; w_wd = init_w_r; w_ra = ptr_r[AW-1:0];
    d_we = 1'b0; d_wa = wa_r; d_wd = '0;       d_ra = ptr_r[AW-1:0];
    b_we = 1'b0; b_wa = idx17[AW-1:0];         b_ra = ptr_r[AW-1:0];

    unique case (state_r)
      S_INIT: begin
        // Clearing pass after reset: weights to their reset value, deltas to zero.
        w_wa = ptr_r[AW-1:0];
        d_wa = ptr_r[AW-1:0];
        w_wd = bpt_pkg::RESET_WEIGHT;
        if (rd_issue) begin
          w_we    = 1'b1;
          d_we    = 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        w_ra = idx17[AW-1:0];
        if (accept) begin
          unique case (in_ch.opcode)
            bpt_pkg::OP_FEATURE: begin
              b_we      = in_range;
              len_nxt   = (len_r < bpt_pkg::MAX_LEN) ? len_r + 1'b1 : len_r;
              state_nxt = S_MUL;
            end
            bpt_pkg::OP_EPOCH: begin
              state_nxt = S_EREP;
            end
            bpt_pkg::OP_RESET_W: begin
              ptr_nxt   = '0;
              wlen_nxt  = NWP;
              state_nxt = S_RWALK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_MUL: begin
        mac_ctrl.mul_en = inr_r;
        state_nxt       = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = bpt_pkg::KIND_SCORE;
          out_score_nxt = score_sat;
          out_miss_nxt  = miss;
          mac_ctrl.clr  = 1'b1;
          len_nxt       = '0;
          if (miss) begin
            err_nxt   = (err_r < bpt_pkg::MAX_ERR) ? err_r + 1'b1 : err_r;
            ptr_nxt   = '0;
            wlen_nxt  = n17[PW-1:0];
            state_nxt = S_DWALK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DWALK: begin
        // Read buffer and delta at ptr; write the updated delta in the following cycle.
        d_we = wv_r;
        d_wd = bpt_pkg::sat32(33'(d_rd_r) + 33'(step));
        if (rd_issue) begin
          wv_nxt  = 1'b1;
          wa_nxt  = ptr_r[AW-1:0];
          ptr_nxt = ptr_r + 1'b1;
        end else if (!wv_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_EREP: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_kind_nxt = bpt_pkg::KIND_EPOCH;
          out_err_nxt  = err_r;
          out_conv_nxt = (err_r == '0);
          err_nxt      = '0;
          mac_ctrl.clr = 1'b1;
          len_nxt      = '0;
          ptr_nxt      = '0;
          wlen_nxt     = NWP;
          state_nxt    = S_EWALK;
        end
      end
      S_EWALK: begin
        w_we = wv_r;
        w_wd = bpt_pkg::sat32(33'(w_rd_r) + 33'(d_rd_r));
        d_we = wv_r;
        d_wd = '0;
        if (rd_issue) begin
          wv_nxt  = 1'b1;
          wa_nxt  = ptr_r[AW-1:0];
          ptr_nxt = ptr_r + 1'b1;
        end else if (!wv_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_RWALK: begin
        w_wa = ptr_r[AW-1:0];
        w_wd = init_w_r;
        if (rd_issue) begin
          w_we    = 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_wa] <= w_wd;
    end
    w_rd_r <= weight_mem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      delta_mem[d_wa] <= d_wd;
    end
    d_rd_r <= delta_mem[d_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      sample_mem[b_wa] <= in_ch.feature_value;
    end
    b_rd_r <= sample_mem[b_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      ptr_r     <= '0;
      wlen_r    <= NWP;
      wv_r      <= 1'b0;
      len_r     <= '0;
      err_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      wlen_r    <= wlen_nxt;
      wv_r      <= wv_nxt;
      len_r     <= len_nxt;
      err_r     <= err_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_w_r <= bpt_pkg::RESET_WEIGHT;
    end else if (cfg_we) begin
      init_w_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    wa_r <= wa_nxt;
    if (accept) begin
      val_r   <= in_ch.feature_value;
      inr_r   <= in_range;
      last_r  <= in_ch.last;
      pos_r   <= in_ch.label_positive;
      train_r <= in_ch.train;
    end
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_score_r <= out_score_nxt;
      out_miss_r  <= out_miss_nxt;
      out_err_r   <= out_err_nxt;
      out_conv_r  <= out_conv_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.score         = out_score_r;
  assign out_ch.misclassified = out_miss_r;
  assign out_ch.epoch_errors  = out_err_r;
  assign out_ch.converged     = out_conv_r;

  // A pipelined walk write must never hit the entry being read in the same cycle.
  `BPT_ASSERT(a_walk_no_overlap, wv_r |-> (wa_r != ptr_r[AW-1:0]),
              "walk write hits read entry")
  // The walk pointer never passes its bound.
  `BPT_ASSERT(a_walk_bound,
              (state_r == S_DWALK || state_r == S_EWALK || state_r == S_RWALK)
              |-> (ptr_r <= wlen_r), "walk pointer overrun")
  // The error count only drops when an epoch report is issued.
  `BPT_ASSERT(a_err_drop, (err_r < $past(err_r)) |-> ($past(state_r) == S_EREP),
              "error count dropped outside epoch report")
  // A score result always starts the next sample from an empty length.
  `BPT_ASSERT(a_len_clear, $past(state_r == S_FIN && slot_free) |-> (len_r == '0),
              "sample length not cleared")

endmodule

[rtl/core/bpt_mac.sv]
// Registered multiply and saturating 64-bit score accumulator.
// Depends on bpt_pkg.
module bpt_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  bpt_pkg::mac_ctrl_t  ctrl,
  input  logic signed [31:0]  weight,
  input  logic signed [15:0]  value,
  output logic signed [63:0]  acc_eff
);

  logic signed [47:0] prod_r;
  logic               pend_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] acc_nxt;
  logic signed [64:0] sum;

  // The product is registered, then folded into the accumulator in the cycle after the multiply.
  assign sum = {acc_r[63], acc_r} + 65'(prod_r);

  always_comb begin
    if (!pend_r) begin
      acc_nxt = acc_r;
    end else if (sum[64] != sum[63]) begin
      acc_nxt = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_nxt = sum[63:0];
    end
  end

  assign acc_eff = acc_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= weight * value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      acc_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      pend_r <= ctrl.mul_en;
    end
  end

endmodule

[test/batch_perceptron_trainer_test.sv]
// Self-checking testbench of the batch perceptron trainer: directed table, then random samples.
// Depends on bpt_pkg, bpt_in_if, bpt_out_if and the batch_perceptron_trainer RTL.
module batch_perceptron_trainer_test;

  localparam int NW = 1024;
  localparam int LIMIT = 3000000;
  // Opcode that the block ignores.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic signed [31:0] cfg_wdata = '0;

  bpt_in_if in_ch();
  bpt_out_if out_ch();

  batch_perceptron_trainer dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One input transaction and one result transaction, as structs; the result one is packed.
  typedef struct {
    logic [1:0] op;
    logic [9:0] idx;
    logic signed [15:0] val;
    logic pos, train, last;
  } item_t;

  typedef struct packed {
    logic kind;
    logic signed [47:0] score;
    logic miss;
    logic [23:0] errs;
    logic conv;
  } result_t;

  // Directed rows: an item, plus an optional typed-in expectation to compare
  // against the predictor's own answer.
  typedef struct {
    item_t it;
    bit has_exp;
    result_t exp;
  } row_t;

  // Shadow state of the trainer.
  logic signed [31:0] weights [NW];
  logic signed [31:0] deltas [NW];
  logic signed [15:0] buffered [NW];
  logic signed [63:0] acc;
  int unsigned slen;
  int unsigned errcnt;
  logic signed [31:0] init_w;

  result_t pending_results[$];
  int failures = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] acc_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    // Overflow only when both operands share a sign and the sum does not.
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  // Appends one expectation to the queue of results still to come.
  task automatic expect_result(input result_t r);
    pending_results = {pending_results, r};
  endtask

  // Advances the shadow state by one accepted item and queues its result, if it has one.
  task automatic train_predict(input item_t it);
    logic signed [47:0] s48;
    logic miss;
    int n;
    case (it.op)
      bpt_pkg::OP_FEATURE: begin
        acc = acc_add(acc, 64'(weights[it.idx]) * 64'(it.val));
        buffered[it.idx] = it.val;
        if (slen < 2047) slen++;
        if (it.last) begin
          if (acc > 64'sh00007FFFFFFFFFFF) s48 = 48'sh7FFFFFFFFFFF;
          else if (acc < -64'sh0000800000000000) s48 = 48'sh800000000000;
          else s48 = acc[47:0];
          miss = it.train && (it.pos ? (s48 < 0) : (s48 > 0));
          if (miss) begin
            n = (slen < NW) ? slen : NW;
            for (int i = 0; i < n; i++)
              deltas[i] = clamp32(longint'(deltas[i]) +
                                  (it.pos ? longint'(buffered[i]) : -longint'(buffered[i])));
            if (errcnt < 24'hFFFFFF) errcnt++;
          end
          acc = 0;
          slen = 0;
          expect_result('{bpt_pkg::KIND_SCORE, s48, miss, 24'd0, 1'b0});
        end
      end
      bpt_pkg::OP_EPOCH: begin
        for (int i = 0; i < NW; i++) begin
          weights[i] = clamp32(longint'(weights[i]) + longint'(deltas[i]));
          deltas[i] = 0;
        end
        expect_result('{bpt_pkg::KIND_EPOCH, 48'sd0, 1'b0, errcnt[23:0], errcnt == 0});
        errcnt = 0;
        acc = 0;
        slen = 0;
      end
      bpt_pkg::OP_RESET_W: for (int i = 0; i < NW; i++) weights[i] = init_w;
      default: ;
    endcase
  endtask

  // Drives one item and holds it until the block takes the transaction.
  task automatic send_item(input item_t it);
    @(posedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= it.op;
    in_ch.feature_index <= it.idx;
    in_ch.feature_value <= it.val;
    in_ch.label_positive <= it.pos;
    in_ch.train <= it.train;
    in_ch.last <= it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    train_predict(it);
    in_ch.valid <= 1'b0;
  endtask

  // Waits for every queued result, then lets an epoch walk or weight load finish.
  task automatic drain_all();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * NW + 20) @(posedge clk);
  endtask

  task automatic write_init_weight(input logic signed [31:0] w);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    init_w = w;
  endtask

  // Streams one sample of n features in index order.
  task automatic send_sample(input int n, input bit pos, input bit trn, input int vmode);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it.op = bpt_pkg::OP_FEATURE;
      it.idx = i[9:0];
      case (vmode)
        0: it.val = 16'($urandom_range(65535));
        1: it.val = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        default: it.val = 16'($signed($urandom_range(8192)) - 4096);
      endcase
      it.pos = pos;
      it.train = trn;
      it.last = (i == n - 1);
      send_item(it);
    end
  endtask

  // Result side: random stalls, compare each result with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction, kind %0d", out_ch.kind);
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.kind !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, out_ch.kind); failures++;
        end
        if (out_ch.score !== e.score) begin
          $error("score expected %0d actual %0d", e.score, out_ch.score); failures++;
        end
        if (out_ch.misclassified !== e.miss) begin
          $error("misclassified expected %0d actual %0d", e.miss, out_ch.misclassified);
          failures++;
        end
        if (out_ch.epoch_errors !== e.errs) begin
          $error("epoch_errors expected %0d actual %0d", e.errs, out_ch.epoch_errors);
          failures++;
        end
        if (out_ch.converged !== e.conv) begin
          $error("converged expected %0d actual %0d", e.conv, out_ch.converged); failures++;
        end
      end
    end
    out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  item_t it;
  row_t rows[$];
  result_t got;

  function automatic item_t mk(logic [1:0] op, int idx, int val, bit pos, bit trn, bit lst);
    item_t r;
    r.op = op; r.idx = idx[9:0]; r.val = val[15:0];
    r.pos = pos; r.train = trn; r.last = lst;
    return r;
  endfunction

  task automatic add_row(input item_t ri, input bit has_exp, input result_t rexp);
    row_t row;
    row.it = ri;
    row.has_exp = has_exp;
    row.exp = rexp;
    rows = {rows, row};
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = bpt_pkg::OP_FEATURE;
    in_ch.feature_index = '0;
    in_ch.feature_value = '0;
    in_ch.label_positive = 1'b0;
    in_ch.train = 1'b0;
    in_ch.last = 1'b0;
    for (int i = 0; i < NW; i++) begin
      weights[i] = bpt_pkg::RESET_WEIGHT; deltas[i] = 0; buffered[i] = 0;
    end
    acc = 0; slen = 0; errcnt = 0; init_w = bpt_pkg::RESET_WEIGHT;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Expectations typed in where they follow at a glance.
    add_row(mk(bpt_pkg::OP_EPOCH, 0, 0, 0, 0, 0), 1, '{bpt_pkg::KIND_EPOCH, 0, 0, 0, 1});
    // 1.0 weight times max value, one feature: score = 4096 * 32767.
    add_row(mk(bpt_pkg::OP_FEATURE, 0, 32767, 1, 1, 1), 1,
            '{bpt_pkg::KIND_SCORE, 48'sd134213632, 0, 0, 0});
    // Negative extreme with positive label is a training error.
    add_row(mk(bpt_pkg::OP_FEATURE, 0, -32768, 1, 1, 1), 1,
            '{bpt_pkg::KIND_SCORE, -48'sd134217728, 1, 0, 0});
    // Zero score is never an error.
    add_row(mk(bpt_pkg::OP_FEATURE, 0, 0, 0, 1, 1), 1, '{bpt_pkg::KIND_SCORE, 0, 0, 0, 0});
    add_row(mk(bpt_pkg::OP_FEATURE, 0, 100, 0, 0, 0), 0, '{0, 0, 0, 0, 0});
    add_row(mk(bpt_pkg::OP_FEATURE, 1, -200, 0, 0, 0), 0, '{0, 0, 0, 0, 0});
    add_row(mk(bpt_pkg::OP_FEATURE, 2, 300, 0, 1, 1), 0, '{0, 0, 0, 0, 0});
    add_row(mk(bpt_pkg::OP_FEATURE, 1023, 5, 0, 0, 0), 0, '{0, 0, 0, 0, 0});
    add_row(mk(bpt_pkg::OP_FEATURE, 0, 5, 1, 0, 1), 0, '{0, 0, 0, 0, 0});
    // The unused opcode is ignored.
    add_row(mk(OP_IGNORED, 1023, -1, 1, 1, 1), 0, '{0, 0, 0, 0, 0});
    add_row(mk(bpt_pkg::OP_EPOCH, 0, 0, 0, 0, 0), 1, '{bpt_pkg::KIND_EPOCH, 0, 0, 2, 0});
    add_row(mk(bpt_pkg::OP_FEATURE, 0, 7, 1, 1, 0), 0, '{0, 0, 0, 0, 0});
    // Epoch in the middle of a sample discards it.
    add_row(mk(bpt_pkg::OP_EPOCH, 0, 0, 0, 0, 0), 1, '{bpt_pkg::KIND_EPOCH, 0, 0, 0, 1});
    add_row(mk(bpt_pkg::OP_RESET_W, 0, 0, 0, 0, 0), 0, '{0, 0, 0, 0, 0});
    add_row(mk(bpt_pkg::OP_FEATURE, 0, 1, 1, 0, 1), 1,
            '{bpt_pkg::KIND_SCORE, 48'sd4096, 0, 0, 0});

    foreach (rows[r]) begin
      send_item(rows[r].it);
      if (rows[r].has_exp) begin
        // The item's own prediction is the newest entry in the queue.
        got = pending_results[$];
        if (got !== rows[r].exp) begin
          $error("row %0d: typed expectation kind %0d score %0d differs from prediction %0d",
                 r, rows[r].exp.kind, rows[r].exp.score, got.score);
          failures++;
        end
      end
    end
    drain_all();

    // Random phases across several initial weights, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_init_weight(32'sh7FFFFFFF);
        1: write_init_weight(32'sh80000000);
        2: write_init_weight(32'sd0);
        3: write_init_weight(32'sd4096);
        4: write_init_weight(-32'sd4096);
        default: write_init_weight($urandom);
      endcase
      if (ph == 0) begin send_idle_pct = 6; recv_idle_pct = 61; end
      else if (ph == 2) begin send_idle_pct = 61; recv_idle_pct = 6; end
      else if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      it = mk(bpt_pkg::OP_RESET_W, 0, 0, 0, 0, 0);
      send_item(it);
      for (int k = 0; k < 22; k++) begin
        case ($urandom_range(19))
          0: send_item(mk(bpt_pkg::OP_EPOCH, 0, 0, 0, 0, 0));
          1: send_item(mk(OP_IGNORED, $urandom_range(1023), $urandom, $urandom_range(1),
                          $urandom_range(1), $urandom_range(1)));
          2: send_item(mk(bpt_pkg::OP_RESET_W, 0, 0, 0, 0, 0));
          3: send_sample(($urandom_range(15) == 0) ? $urandom_range(40, 12) : 1,
                         $urandom_range(1), 1, 1);
          default: send_sample($urandom_range(6, 1), $urandom_range(1),
                               $urandom_range(3) != 0, $urandom_range(2));
        endcase
        // Hold the sender back until every result has arrived, once per phase.
        if (k == 11) while (pending_results.size() != 0) @(posedge clk);
      end
      // One long sample touching the top of the index range.
      if (ph == 5) send_sample(NW, $urandom_range(1), 1, 2);
      send_item(mk(bpt_pkg::OP_EPOCH, 0, 0, 0, 0, 0));
      drain_all();
    end

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
